FILE: src/vlv_pkg.sv
`timescale 1ns / 1ps

package vlv_pkg;

   // Field widths fixed by the interface
   localparam int NOTE_W    = 7;
   localparam int NOTE_PORTS = 4;
   localparam int COST_W    = 31;
   localparam int PEN_W     = 16;
   localparam int SQ_W      = 14;
   localparam int TRANS_W   = 19;
   localparam int OUT_IDX_W = 6;

   localparam logic [COST_W-1:0] COST_MAX        = {COST_W{1'b1}};
   localparam logic [PEN_W-1:0]  PENALTY_DEFAULT = 16'd1000;

   // Defaults for the top-level parameters
   localparam int VOICES_DEFAULT         = 4;
   localparam int MAX_CANDIDATES_DEFAULT = 64;
   localparam int MAX_BARS_DEFAULT       = 64;

   // Control into the merging stage
   typedef struct packed {
      logic valid;
      logic clear;
   } mrg_ctl_type;

   // Status out of the merging stage
   typedef struct packed {
      logic busy;
   } mrg_sts_type;

   // Remainder of a 7-bit magnitude by 12, by reciprocal and one correction
   function automatic logic [3:0] mod12(input logic [NOTE_W-1:0] m);
      logic [12:0] prod;
      logic [3:0]  quo;
      logic [7:0]  rem;
      prod = {6'd0, m} * 13'd43;
      quo  = prod[12:9];
      rem  = {1'b0, m} - ({4'd0, quo} * 8'd12);
      if (rem >= 8'd12) begin
         rem = rem - 8'd12;
      end
      return rem[3:0];
   endfunction

endpackage

FILE: src/vlv_lane.sv
`timescale 1ns / 1ps

// One voice: squared move from the stored note to the new note
module vlv_lane (
   input  logic                             clock,
   input  logic [vlv_pkg::NOTE_W-1:0]      prev_note,
   input  logic [vlv_pkg::NOTE_W-1:0]      new_note,
   output logic [vlv_pkg::SQ_W-1:0]        sq_move
);

   logic signed [vlv_pkg::NOTE_W:0] diff;
   logic [vlv_pkg::NOTE_W-1:0]      mag;
   logic [vlv_pkg::SQ_W-1:0]        sq_ff;
   logic [vlv_pkg::SQ_W-1:0]        sq_in;

   // Take magnitude of the move and square it
   always_comb begin
      diff  = $signed({1'b0, prev_note}) - $signed({1'b0, new_note});
      mag   = diff[vlv_pkg::NOTE_W] ? vlv_pkg::NOTE_W'(-diff) : diff[vlv_pkg::NOTE_W-1:0];
      sq_in = mag * mag;
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign sq_move = sq_ff;

endmodule

FILE: src/vlv_pair.sv
`timescale 1ns / 1ps

// One voice pair: penalty when an octave or fifth moves in parallel
module vlv_pair (
   input  logic                          clock,
   input  logic [vlv_pkg::NOTE_W-1:0]   prev_hi,
   input  logic [vlv_pkg::NOTE_W-1:0]   prev_lo,
   input  logic [vlv_pkg::NOTE_W-1:0]   new_hi,
   input  logic [vlv_pkg::NOTE_W-1:0]   new_lo,
   input  logic [vlv_pkg::PEN_W-1:0]    penalty,
   output logic [vlv_pkg::PEN_W-1:0]    pen
);

   logic signed [vlv_pkg::NOTE_W:0] d_prev;
   logic signed [vlv_pkg::NOTE_W:0] d_new;
   logic [vlv_pkg::NOTE_W-1:0]      mag;
   logic [3:0]                      rem;
   logic                            forbidden;
   logic [vlv_pkg::PEN_W-1:0]       pen_ff;
   logic [vlv_pkg::PEN_W-1:0]       pen_in;

   // Truncated remainder: a negative interval only counts on a multiple of 12
   always_comb begin
      d_prev    = $signed({1'b0, prev_hi}) - $signed({1'b0, prev_lo});
      d_new     = $signed({1'b0, new_hi}) - $signed({1'b0, new_lo});
      mag       = d_prev[vlv_pkg::NOTE_W] ? vlv_pkg::NOTE_W'(-d_prev)
                                          : d_prev[vlv_pkg::NOTE_W-1:0];
      rem       = vlv_pkg::mod12(mag);
      forbidden = (rem == 4'd0) || (!d_prev[vlv_pkg::NOTE_W] && rem == 4'd7);
      pen_in    = (forbidden && d_new == d_prev) ? penalty : '0;
   end

   always_ff @(posedge clock) begin
      pen_ff <= pen_in;
   end

   assign pen = pen_ff;

endmodule

FILE: src/vlv_merge.sv
`timescale 1ns / 1ps

// Merge lane results into a path cost and keep the cheapest predecessor
module vlv_merge #(
   parameter int NV   = 4,
   parameter int NP   = 6,
   parameter int IDXW = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  vlv_pkg::mrg_ctl_type            ctl,
   input  logic [IDXW-1:0]                 idx,
   input  logic [NV*vlv_pkg::SQ_W-1:0]     sq_moves,
   input  logic [NP*vlv_pkg::PEN_W-1:0]    pens,
   input  logic [vlv_pkg::COST_W-1:0]      prev_cost,
   output logic [vlv_pkg::COST_W-1:0]      best_cost,
   output logic [IDXW-1:0]                 best_idx,
   output vlv_pkg::mrg_sts_type            sts
);

   logic [vlv_pkg::TRANS_W-1:0] trans_in;
   logic [vlv_pkg::TRANS_W-1:0] trans_ff;
   logic [vlv_pkg::COST_W-1:0]  prev_ff;
   logic [IDXW-1:0]             idx_ff;
   logic                        valid_ff;
   logic [vlv_pkg::COST_W:0]    total;
   logic [vlv_pkg::COST_W-1:0]  path_cost;
   logic [vlv_pkg::COST_W-1:0]  best_ff;
   logic [IDXW-1:0]             best_idx_ff;

   // Sum the lane outputs
   always_comb begin
      trans_in = '0;
      for (int v = 0; v < NV; v++) begin
         trans_in = trans_in
                  + vlv_pkg::TRANS_W'(sq_moves[v*vlv_pkg::SQ_W +: vlv_pkg::SQ_W]);
      end
      for (int p = 0; p < NP; p++) begin
         trans_in = trans_in
                  + vlv_pkg::TRANS_W'(pens[p*vlv_pkg::PEN_W +: vlv_pkg::PEN_W]);
      end
   end

   // Add the stored path cost and saturate
   always_comb begin
      total     = {1'b0, prev_ff} + (vlv_pkg::COST_W+1)'(trans_ff);
      path_cost = total[vlv_pkg::COST_W] ? vlv_pkg::COST_MAX : total[vlv_pkg::COST_W-1:0];
   end

   always_ff @(posedge clock) begin
      trans_ff <= trans_in;
      prev_ff  <= prev_cost;
      idx_ff   <= idx;
   end

   // Hold the first cheapest predecessor
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         best_ff     <= vlv_pkg::COST_MAX;
         best_idx_ff <= '0;
      end else begin
         valid_ff <= ctl.valid;
         if (ctl.clear) begin
            best_ff     <= vlv_pkg::COST_MAX;
            best_idx_ff <= '0;
         end else if (valid_ff && path_cost < best_ff) begin
            best_ff     <= path_cost;
            best_idx_ff <= idx_ff;
         end
      end
   end

   assign best_cost = best_ff;
   assign best_idx  = best_idx_ff;
   assign sts.busy  = valid_ff;

endmodule

FILE: src/voice_leading_viterbi.sv
`timescale 1ns / 1ps

// Voice-leading path search over a stream of candidate voicings.
// Write the parallel penalty on the csr_ channel while the block is idle;
// csr_ready is always high. Send candidates on the req_ channel, one word
// per candidate, with req_bar_end on the last of each bar and
// req_progression_end on the last of the progression. Each candidate is
// scored against every stored candidate of the previous bar, one per cycle,
// through per-voice and per-pair lanes and a merging stage. At the end of
// a progression the last bar's costs are scanned and one rsp_ word per bar
// is sent, last bar first, from the back-pointer memory. A stalled rsp_
// word holds; the trace waits on it. After the last word is loaded, the
// bar and candidate counts and the overflow flags clear, the penalty is
// kept and req_ready returns. Reset is synchronous and clears the
// counters and sets the penalty to 1000; the memories need no clearing.
module voice_leading_viterbi #(
   parameter int VOICES         = vlv_pkg::VOICES_DEFAULT,
   parameter int MAX_CANDIDATES = vlv_pkg::MAX_CANDIDATES_DEFAULT,
   parameter int MAX_BARS       = vlv_pkg::MAX_BARS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vlv_pkg::PEN_W-1:0]         csr_parallel_penalty,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vlv_pkg::NOTE_W-1:0]        req_note_0,
   input  logic [vlv_pkg::NOTE_W-1:0]        req_note_1,
   input  logic [vlv_pkg::NOTE_W-1:0]        req_note_2,
   input  logic [vlv_pkg::NOTE_W-1:0]        req_note_3,
   input  logic                              req_bar_end,
   input  logic                              req_progression_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vlv_pkg::OUT_IDX_W-1:0]     rsp_bar_number,
   output logic [vlv_pkg::OUT_IDX_W-1:0]     rsp_chosen_candidate,
   output logic [vlv_pkg::COST_W-1:0]        rsp_total_cost,
   output logic                              rsp_overflowed,
   output logic                              rsp_last_choice
);

   localparam int NV   = (VOICES < vlv_pkg::NOTE_PORTS) ? VOICES : vlv_pkg::NOTE_PORTS;
   localparam int NP   = NV * (NV - 1) / 2;
   localparam int CW   = $clog2(MAX_CANDIDATES);
   localparam int CNTW = $clog2(MAX_CANDIDATES + 1);
   localparam int BW   = $clog2(MAX_BARS);
   localparam int NW   = vlv_pkg::NOTE_PORTS * vlv_pkg::NOTE_W;
   localparam int OW   = vlv_pkg::OUT_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRITE,
      ST_FINISH,
      ST_SCAN,
      ST_EMIT,
      ST_TRACE
   } state_type;

   state_type                   state_ff;
   logic [vlv_pkg::PEN_W-1:0]   penalty_ff;
   logic [NW-1:0]               notes_ff;
   logic                        bar_end_ff;
   logic                        prog_end_ff;
   logic [BW-1:0]               bar_ff;
   logic [CNTW-1:0]             cnt0_ff;
   logic [CNTW-1:0]             cnt1_ff;
   logic                        bank_ff;
   logic                        overflow_ff;
   logic                        bars_full_ff;
   logic [CNTW-1:0]             k_ff;
   logic                        v1_ff;
   logic [CW-1:0]               k1_ff;
   logic                        v2_ff;
   logic [CW-1:0]               k2_ff;
   logic [vlv_pkg::COST_W-1:0]  cost2_ff;
   logic [vlv_pkg::COST_W-1:0]  wr_cost_ff;
   logic [CW-1:0]               wr_back_ff;
   logic [vlv_pkg::COST_W-1:0]  scan_best_ff;
   logic [CW-1:0]               scan_idx_ff;
   logic [BW-1:0]               tr_bar_ff;
   logic [CW-1:0]               tr_j_ff;
   logic                        rsp_valid_ff;
   logic [OW-1:0]               rsp_bar_ff;
   logic [OW-1:0]               rsp_cand_ff;
   logic [vlv_pkg::COST_W-1:0]  rsp_cost_ff;
   logic                        rsp_ovf_ff;
   logic                        rsp_last_ff;
   logic [vlv_pkg::COST_W-1:0]  total_ff;

   // Candidate store: two banks, previous and current bar
   logic [NW-1:0]               note_mem [2*MAX_CANDIDATES];
   logic [vlv_pkg::COST_W-1:0]  cost_mem [2*MAX_CANDIDATES];
   logic [NW-1:0]               note_rd_ff;
   logic [vlv_pkg::COST_W-1:0]  cost_rd_ff;
   logic [CW:0]                 st_rd_addr;
   logic [CW:0]                 st_wr_addr;
   logic                        st_rd_en;
   logic                        st_wr_en;

   // Back-pointer store, one row per bar
   logic [CW-1:0]               bp_mem [2**(BW+CW)];
   logic [CW-1:0]               bp_rd_ff;
   logic                        bp_rd_en;
   logic                        bp_wr_en;

   logic                        req_fire;
   logic                        drop;
   logic                        first_search;
   logic [CNTW-1:0]             rd_limit;
   logic                        out_free;
   logic [BW+OW-1:0]            bar_ext;
   logic [CW+OW-1:0]            cand_ext;

   vlv_pkg::mrg_ctl_type        mrg_ctl;
   vlv_pkg::mrg_sts_type        mrg_sts;
   logic [vlv_pkg::COST_W-1:0]  mrg_best_cost;
   logic [CW-1:0]               mrg_best_idx;
   logic [NV*vlv_pkg::SQ_W-1:0]  sq_moves;
   logic [NP*vlv_pkg::PEN_W-1:0] pens;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign drop      = bars_full_ff || (cnt1_ff >= CNTW'(MAX_CANDIDATES));
   assign first_search = req_fire && !drop && (bar_ff != '0) && (cnt0_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Pick the read bank: previous bar while searching, current bar while scanning
   always_comb begin
      rd_limit   = (state_ff == ST_SCAN) ? cnt1_ff : cnt0_ff;
      st_rd_en   = ((state_ff == ST_SEARCH) || (state_ff == ST_SCAN)) && (k_ff < rd_limit);
      st_rd_addr = {(state_ff == ST_SCAN) ? bank_ff : !bank_ff, k_ff[CW-1:0]};
      st_wr_en   = (state_ff == ST_WRITE);
      st_wr_addr = {bank_ff, cnt1_ff[CW-1:0]};
      bp_wr_en   = (state_ff == ST_WRITE);
      bp_rd_en   = (state_ff == ST_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (st_wr_en) begin
         note_mem[st_wr_addr] <= notes_ff;
         cost_mem[st_wr_addr] <= wr_cost_ff;
      end
      if (st_rd_en) begin
         note_rd_ff <= note_mem[st_rd_addr];
         cost_rd_ff <= cost_mem[st_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bp_wr_en) begin
         bp_mem[{bar_ff, cnt1_ff[CW-1:0]}] <= wr_back_ff;
      end
      if (bp_rd_en) begin
         bp_rd_ff <= bp_mem[{tr_bar_ff, tr_j_ff}];
      end
   end

   // Lanes: one per voice, one per voice pair
   for (genvar v = 0; v < NV; v++) begin : g_lane
      vlv_lane u_lane (
         .clock     (clock),
         .prev_note (note_rd_ff[v*vlv_pkg::NOTE_W +: vlv_pkg::NOTE_W]),
         .new_note  (notes_ff[v*vlv_pkg::NOTE_W +: vlv_pkg::NOTE_W]),
         .sq_move   (sq_moves[v*vlv_pkg::SQ_W +: vlv_pkg::SQ_W])
      );
   end

   for (genvar i = 1; i < NV; i++) begin : g_hi
      for (genvar j = 0; j < i; j++) begin : g_lo
         localparam int P = i * (i - 1) / 2 + j;
         vlv_pair u_pair (
            .clock   (clock),
            .prev_hi (note_rd_ff[i*vlv_pkg::NOTE_W +: vlv_pkg::NOTE_W]),
            .prev_lo (note_rd_ff[j*vlv_pkg::NOTE_W +: vlv_pkg::NOTE_W]),
            .new_hi  (notes_ff[i*vlv_pkg::NOTE_W +: vlv_pkg::NOTE_W]),
            .new_lo  (notes_ff[j*vlv_pkg::NOTE_W +: vlv_pkg::NOTE_W]),
            .penalty (penalty_ff),
            .pen     (pens[P*vlv_pkg::PEN_W +: vlv_pkg::PEN_W])
         );
      end
   end

   assign mrg_ctl.valid = v2_ff && (state_ff == ST_SEARCH);
   assign mrg_ctl.clear = first_search;

   vlv_merge #(
      .NV   (NV),
      .NP   (NP),
      .IDXW (CW)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mrg_ctl),
      .idx       (k2_ff),
      .sq_moves  (sq_moves),
      .pens      (pens),
      .prev_cost (cost2_ff),
      .best_cost (mrg_best_cost),
      .best_idx  (mrg_best_idx),
      .sts       (mrg_sts)
   );

   // Widen or trim indexes to the result fields
   assign bar_ext  = {{OW{1'b0}}, tr_bar_ff};
   assign cand_ext = {{OW{1'b0}}, tr_j_ff};

   // Payload pipeline alongside the store reads
   always_ff @(posedge clock) begin
      k1_ff    <= k_ff[CW-1:0];
      k2_ff    <= k1_ff;
      cost2_ff <= cost_rd_ff;
      if (req_fire) begin
         notes_ff    <= {req_note_3, req_note_2, req_note_1, req_note_0};
         bar_end_ff  <= req_bar_end;
         prog_end_ff <= req_progression_end;
      end
   end

   // Sequencer, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         penalty_ff   <= vlv_pkg::PENALTY_DEFAULT;
         bar_ff       <= '0;
         cnt0_ff      <= '0;
         cnt1_ff      <= '0;
         bank_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         bars_full_ff <= 1'b0;
         k_ff         <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            penalty_ff <= csr_parallel_penalty;
         end
         v1_ff <= st_rd_en;
         v2_ff <= v1_ff && (state_ff == ST_SEARCH);
         // Drop a taken word unless a new one is loaded below
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (drop) begin
                     overflow_ff <= 1'b1;
                     state_ff    <= ST_FINISH;
                  end else if (first_search) begin
                     k_ff     <= '0;
                     state_ff <= ST_SEARCH;
                  end else begin
                     wr_cost_ff <= (bar_ff == '0) ? '0 : vlv_pkg::COST_MAX;
                     wr_back_ff <= '0;
                     state_ff   <= ST_WRITE;
                  end
               end
            end

            // Issue one predecessor a cycle, then drain the lanes
            ST_SEARCH: begin
               if (st_rd_en) begin
                  k_ff <= k_ff + 1'b1;
               end else if (!v1_ff && !v2_ff && !mrg_sts.busy) begin
                  wr_cost_ff <= mrg_best_cost;
                  wr_back_ff <= mrg_best_idx;
                  state_ff   <= ST_WRITE;
               end
            end

            ST_WRITE: begin
               cnt1_ff  <= cnt1_ff + 1'b1;
               state_ff <= ST_FINISH;
            end

            // Close the bar or start the final scan
            ST_FINISH: begin
               if (prog_end_ff) begin
                  k_ff         <= '0;
                  scan_best_ff <= vlv_pkg::COST_MAX;
                  scan_idx_ff  <= '0;
                  state_ff     <= ST_SCAN;
               end else begin
                  if (bar_end_ff && !bars_full_ff) begin
                     if (bar_ff == BW'(MAX_BARS - 1)) begin
                        bars_full_ff <= 1'b1;
                     end else begin
                        bank_ff <= !bank_ff;
                        cnt0_ff <= cnt1_ff;
                        cnt1_ff <= '0;
                        bar_ff  <= bar_ff + 1'b1;
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end

            // Find the first cheapest candidate of the last bar
            ST_SCAN: begin
               if (v1_ff && cost_rd_ff < scan_best_ff) begin
                  scan_best_ff <= cost_rd_ff;
                  scan_idx_ff  <= k1_ff;
               end
               if (st_rd_en) begin
                  k_ff <= k_ff + 1'b1;
               end else if (!v1_ff) begin
                  total_ff  <= (cnt1_ff == '0) ? '0 : scan_best_ff;
                  tr_j_ff   <= scan_idx_ff;
                  tr_bar_ff <= bar_ff;
                  state_ff  <= ST_EMIT;
               end
            end

            // Load one result word and fetch the back pointer
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bar_ff   <= bar_ext[OW-1:0];
                  rsp_cand_ff  <= cand_ext[OW-1:0];
                  rsp_cost_ff  <= total_ff;
                  rsp_ovf_ff   <= overflow_ff;
                  rsp_last_ff  <= (tr_bar_ff == '0);
                  if (tr_bar_ff == '0) begin
                     bar_ff       <= '0;
                     cnt0_ff      <= '0;
                     cnt1_ff      <= '0;
                     overflow_ff  <= 1'b0;
                     bars_full_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_TRACE;
                  end
               end
            end

            ST_TRACE: begin
               tr_j_ff   <= bp_rd_ff;
               tr_bar_ff <= tr_bar_ff - 1'b1;
               state_ff  <= ST_EMIT;
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bar_number       = rsp_bar_ff;
   assign rsp_chosen_candidate = rsp_cand_ff;
   assign rsp_total_cost       = rsp_cost_ff;
   assign rsp_overflowed       = rsp_ovf_ff;
   assign rsp_last_choice      = rsp_last_ff;

endmodule

FILE: sim/voice_leading_viterbi_tb.sv
`timescale 1ns / 1ps

module voice_leading_viterbi_tb;

   localparam int CANDS = vlv_pkg::MAX_CANDIDATES_DEFAULT;
   localparam int BARS  = vlv_pkg::MAX_BARS_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;

   typedef logic [vlv_pkg::NOTE_PORTS-1:0][vlv_pkg::NOTE_W-1:0] voicing_type;

   typedef struct {
      logic [vlv_pkg::OUT_IDX_W-1:0] bar_number;
      logic [vlv_pkg::OUT_IDX_W-1:0] chosen_candidate;
      logic [vlv_pkg::COST_W-1:0]    total_cost;
      logic                          overflowed;
      logic                          last_choice;
   } choice_type;

   // Path search predictor and store of expected choices
   class scoreboard_type;
      voicing_type               prev_notes[CANDS];
      voicing_type               cur_notes[CANDS];
      longint                    prev_cost[CANDS];
      longint                    cur_cost[CANDS];
      logic [5:0]                back_ptr[BARS][CANDS];
      int                        bar_cnt;
      int                        n_prev;
      int                        n_cur;
      bit                        dropped;
      bit                        bars_done;
      logic [vlv_pkg::PEN_W-1:0] penalty;
      choice_type                expected_choices[$];
      int                        errors;

      function new();
         penalty = vlv_pkg::PENALTY_DEFAULT;
         errors  = 0;
         clear();
      endfunction

      function void clear();
         bar_cnt   = 0;
         n_prev    = 0;
         n_cur     = 0;
         dropped   = 0;
         bars_done = 0;
      endfunction

      function int pending();
         return expected_choices.size();
      endfunction

      // Cost of moving from voicing a to voicing b
      function longint move_cost(voicing_type a, voicing_type b);
         longint c;
         int d;
         c = 0;
         for (int i = 0; i < 4; i++) begin
            d = int'(a[i]) - int'(b[i]);
            c += d * d;
         end
         for (int i = 1; i < 4; i++) begin
            for (int j = 0; j < i; j++) begin
               d = int'(a[i]) - int'(a[j]);
               if ((d % 12 == 0 || d % 12 == 7) && int'(b[i]) == int'(b[j]) + d) begin
                  c += penalty;
               end
            end
         end
         return c;
      endfunction

      // Advance the search by one accepted word
      function void note_input(voicing_type v, bit bar_end, bit prog_end);
         longint best, c, bestcost;
         int back, j, pick;
         choice_type ch;
         if (bars_done || n_cur >= CANDS) begin
            dropped = 1;
         end else begin
            best = 0;
            back = 0;
            if (bar_cnt != 0) begin
               best = vlv_pkg::COST_MAX;
               for (int k = 0; k < n_prev; k++) begin
                  c = prev_cost[k] + move_cost(prev_notes[k], v);
                  if (c > vlv_pkg::COST_MAX) c = vlv_pkg::COST_MAX;
                  if (c < best) begin
                     best = c;
                     back = k;
                  end
               end
            end
            cur_notes[n_cur] = v;
            cur_cost[n_cur]  = best;
            back_ptr[bar_cnt % BARS][n_cur] = back[5:0];
            n_cur++;
         end
         if (prog_end) begin
            pick = 0;
            bestcost = vlv_pkg::COST_MAX;
            for (int k = 0; k < n_cur; k++) begin
               if (cur_cost[k] < bestcost) begin
                  bestcost = cur_cost[k];
                  pick = k;
               end
            end
            if (n_cur == 0) bestcost = 0;
            j = pick;
            for (int b = bar_cnt % BARS; b >= 0; b--) begin
               ch.bar_number       = b[5:0];
               ch.chosen_candidate = j[5:0];
               ch.total_cost       = bestcost[vlv_pkg::COST_W-1:0];
               ch.overflowed       = dropped;
               ch.last_choice      = (b == 0);
               expected_choices    = {expected_choices, ch};
               j = back_ptr[b][j % CANDS];
            end
            clear();
         end else if (bar_end && !bars_done) begin
            if (bar_cnt + 1 >= BARS) begin
               bars_done = 1;
            end else begin
               prev_notes = cur_notes;
               prev_cost  = cur_cost;
               n_prev     = n_cur;
               n_cur      = 0;
               bar_cnt++;
            end
         end
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      // Compare one result word against the oldest expectation
      task check_result(choice_type got);
         choice_type want;
         if (expected_choices.size() == 0) begin
            report("unexpected word, bar", got.bar_number, -1);
         end else begin
            want = expected_choices.pop_front();
            if (got.bar_number !== want.bar_number)
               report("bar_number", got.bar_number, want.bar_number);
            if (got.chosen_candidate !== want.chosen_candidate)
               report("chosen_candidate", got.chosen_candidate, want.chosen_candidate);
            if (got.total_cost !== want.total_cost)
               report("total_cost", got.total_cost, want.total_cost);
            if (got.overflowed !== want.overflowed)
               report("overflowed", got.overflowed, want.overflowed);
            if (got.last_choice !== want.last_choice)
               report("last_choice", got.last_choice, want.last_choice);
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [vlv_pkg::PEN_W-1:0] csr_parallel_penalty;
   logic req_valid;
   logic req_ready;
   logic [vlv_pkg::NOTE_W-1:0] req_note_0, req_note_1, req_note_2, req_note_3;
   logic req_bar_end;
   logic req_progression_end;
   logic rsp_valid;
   logic rsp_ready;
   logic [vlv_pkg::OUT_IDX_W-1:0] rsp_bar_number;
   logic [vlv_pkg::OUT_IDX_W-1:0] rsp_chosen_candidate;
   logic [vlv_pkg::COST_W-1:0] rsp_total_cost;
   logic rsp_overflowed;
   logic rsp_last_choice;

   scoreboard_type sb;
   int  cycles;
   int  words_sent;
   int  snd_idle_pct;
   int  rcv_idle_pct;
   int  hold_left;
   bit  hold_go;
   bit  hold_used;
   voicing_type last_v;

   voice_leading_viterbi dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_parallel_penalty(csr_parallel_penalty),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_note_0(req_note_0), .req_note_1(req_note_1),
      .req_note_2(req_note_2), .req_note_3(req_note_3),
      .req_bar_end(req_bar_end), .req_progression_end(req_progression_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_bar_number(rsp_bar_number), .rsp_chosen_candidate(rsp_chosen_candidate),
      .rsp_total_cost(rsp_total_cost), .rsp_overflowed(rsp_overflowed),
      .rsp_last_choice(rsp_last_choice)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("voice_leading_viterbi_tb: FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Collect result words
   always @(posedge clock) begin
      choice_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.bar_number       = rsp_bar_number;
         got.chosen_candidate = rsp_chosen_candidate;
         got.total_cost       = rsp_total_cost;
         got.overflowed       = rsp_overflowed;
         got.last_choice      = rsp_last_choice;
         sb.check_result(got);
      end
   end

   // Offer one candidate word and hold it until accepted
   task send_word(voicing_type v, bit bar_end, bit prog_end);
      if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_note_0          <= v[0];
      req_note_1          <= v[1];
      req_note_2          <= v[2];
      req_note_3          <= v[3];
      req_bar_end         <= bar_end;
      req_progression_end <= prog_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(v, bar_end, prog_end);
      last_v = v;
      words_sent++;
      if (words_sent < 120) begin
         snd_idle_pct = 19;
         rcv_idle_pct = 63;
      end else if (words_sent < 240) begin
         snd_idle_pct = 63;
         rcv_idle_pct = 19;
      end else begin
         snd_idle_pct = 0;
         rcv_idle_pct = 0;
      end
   endtask

   // Drain results, let the block settle, then write the penalty
   task write_penalty(logic [vlv_pkg::PEN_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_valid            <= 1'b1;
      csr_parallel_penalty <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.penalty = value;
   endtask

   function voicing_type mk(int a, int b, int c, int d);
      voicing_type v;
      v[0] = a[6:0];
      v[1] = b[6:0];
      v[2] = c[6:0];
      v[3] = d[6:0];
      return v;
   endfunction

   // Random voicing: plain noise, a shifted copy of the last one, or stacked
   // fifths and octaves
   function voicing_type rand_voicing();
      voicing_type v;
      int sel, off, base, lo, hi;
      sel = $urandom_range(2);
      if (sel == 1) begin
         lo = 127;
         hi = 0;
         for (int i = 0; i < 4; i++) begin
            if (last_v[i] < lo) lo = last_v[i];
            if (last_v[i] > hi) hi = last_v[i];
         end
         off = int'($urandom_range(10)) - 5;
         if (lo + off < 0) off = -lo;
         if (hi + off > 127) off = 127 - hi;
         for (int i = 0; i < 4; i++) v[i] = 7'(int'(last_v[i]) + off);
      end else if (sel == 2) begin
         base = $urandom_range(90);
         v[0] = 7'(base);
         for (int i = 1; i < 4; i++) begin
            base += ($urandom_range(1) ? 7 : 12) - ($urandom_range(3) == 0 ? 7 : 0);
            if (base > 127) base = 127;
            v[i] = 7'(base);
         end
         if ($urandom_range(1)) v = {v[0], v[1], v[2], v[3]};
      end else begin
         for (int i = 0; i < 4; i++) v[i] = 7'($urandom_range(127));
      end
      return v;
   endfunction

   // One progression of random content; bar_end may be left off the final word
   task run_progression(int nbars, int max_cands);
      int nc;
      bit pe;
      for (int b = 0; b < nbars; b++) begin
         nc = $urandom_range(1, max_cands);
         for (int k = 0; k < nc; k++) begin
            pe = (b == nbars - 1) && (k == nc - 1);
            send_word(rand_voicing(), (k == nc - 1) && !(pe && $urandom_range(1)), pe);
         end
      end
   endtask

   initial begin
      int prog;
      sb = new();
      cycles = 0;
      words_sent = 0;
      snd_idle_pct = 19;
      rcv_idle_pct = 63;
      hold_left = 0;
      hold_go = 0;
      hold_used = 0;
      last_v = '0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_parallel_penalty = '0;
      req_valid = 1'b0;
      req_note_0 = '0;
      req_note_1 = '0;
      req_note_2 = '0;
      req_note_3 = '0;
      req_bar_end = 1'b0;
      req_progression_end = 1'b0;
      rsp_ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default penalty, extremes, parallel moves, ties, end without bar end
      send_word(mk(60, 64, 67, 72), 0, 0);
      send_word(mk(0, 0, 0, 0), 0, 0);
      send_word(mk(127, 127, 127, 127), 1, 0);
      send_word(mk(62, 66, 69, 74), 0, 0);
      send_word(mk(60, 64, 67, 72), 0, 0);
      send_word(mk(127, 0, 127, 0), 0, 0);
      send_word(mk(0, 127, 0, 127), 1, 0);
      send_word(mk(48, 55, 60, 67), 0, 0);
      send_word(mk(127, 120, 115, 108), 0, 1);
      send_word(mk(85, 42, 21, 106), 1, 1);
      write_penalty(16'hFFFF);
      send_word(mk(50, 57, 62, 69), 1, 0);
      send_word(mk(52, 59, 64, 71), 0, 0);
      send_word(mk(53, 60, 65, 72), 1, 0);
      send_word(mk(67, 60, 55, 48), 0, 0);
      send_word(mk(65, 58, 53, 46), 1, 1);
      write_penalty(16'h0000);
      send_word(mk(50, 57, 62, 69), 1, 0);
      send_word(mk(52, 59, 64, 71), 0, 1);

      // Capacity: one oversized bar, then a progression longer than the bar store
      write_penalty(16'd1000);
      for (int k = 0; k < CANDS + 4; k++)
         send_word(rand_voicing(), k == CANDS + 3, 0);
      run_progression(2, 3);
      for (int b = 0; b < BARS + 3; b++)
         send_word(rand_voicing(), 1, b == BARS + 2);

      // Random progressions, mostly short, penalty changed now and then
      prog = 0;
      while (words_sent < 350) begin
         if (prog % 4 == 3)
            write_penalty($urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(65535)));
         if (words_sent >= 240 && !hold_used) begin
            hold_go   = 1;
            hold_used = 1;
         end
         run_progression($urandom_range(1, 6), $urandom_range(1, 5));
         prog++;
      end
      req_valid <= 1'b0;

      // Drain and settle
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("voice_leading_viterbi_tb: PASS");
      end else begin
         $display("voice_leading_viterbi_tb: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/vlv_pkg.sv
src/vlv_lane.sv
src/vlv_pair.sv
src/vlv_merge.sv
src/voice_leading_viterbi.sv
sim/voice_leading_viterbi_tb.sv
